FILE: rtl/core/banked_memory_map_decoder_macros.svh
// Assertion macros for the banked memory map decoder.
// No dependencies. Define ASSERT_OFF to compile the checks out.
`ifndef BANKED_MEMORY_MAP_DECODER_MACROS_SVH
`define BANKED_MEMORY_MAP_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
`define BMMD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BMMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BMMD_ASSERT(lbl, prop, msg)
`define BMMD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/core/bmmd_pkg.sv
// Shared types, codes and decode helpers for the banked memory map decoder.
// No dependencies.
package bmmd_pkg;

    typedef logic [2:0]  req_t;
    typedef logic [15:0] addr_t;
    typedef logic [7:0]  byte_t;
    typedef logic [2:0]  io_t;
    typedef logic [2:0]  src_t;
    typedef logic [5:0]  port_t;

    // Request codes
    localparam req_t REQ_READ     = 3'd0;
    localparam req_t REQ_WRITE    = 3'd1;
    localparam req_t REQ_LD_KERN  = 3'd2;
    localparam req_t REQ_LD_BASIC = 3'd3;
    localparam req_t REQ_LD_CHAR  = 3'd4;

    // Device selects
    localparam io_t IO_NONE  = 3'd0;
    localparam io_t IO_VIDEO = 3'd1;
    localparam io_t IO_CIA1  = 3'd2;
    localparam io_t IO_CIA2  = 3'd3;
    localparam io_t IO_SOUND = 3'd4;
    localparam io_t IO_EXT   = 3'd5;

    // Read data sources
    localparam src_t SRC_IMM    = 3'd0;
    localparam src_t SRC_RAM    = 3'd1;
    localparam src_t SRC_KERNAL = 3'd2;
    localparam src_t SRC_BASIC  = 3'd3;
    localparam src_t SRC_CHAR   = 3'd4;

    localparam byte_t DIR_RESET = 8'h2F;
    localparam byte_t OUT_RESET = 8'h37;
    localparam byte_t IO_FILL   = 8'hFF;

    localparam addr_t ADDR_DIR  = 16'h0000;
    localparam addr_t ADDR_PORT = 16'h0001;

    localparam int RAM_DEPTH  = 65536;
    localparam int KERN_DEPTH = 8192;
    localparam int BAS_DEPTH  = 8192;
    localparam int CHR_DEPTH  = 4096;
    localparam int KERN_AW    = $clog2(KERN_DEPTH);
    localparam int BAS_AW     = $clog2(BAS_DEPTH);
    localparam int CHR_AW     = $clog2(CHR_DEPTH);

    // Port bits
    localparam int BIT_LORAM  = 0;
    localparam int BIT_HIRAM  = 1;
    localparam int BIT_CHAREN = 2;

    function automatic port_t port_value(input byte_t dir, input byte_t outv);
        byte_t v;
        v = outv | ~dir;
        return v[5:0];
    endfunction

    function automatic logic in_d_window(input addr_t a);
        return a inside {[16'hD000:16'hDFFF]};
    endfunction

    function automatic io_t io_select(input addr_t a);
        io_t t;
        if (a inside {[16'hD400:16'hD7FF]})
            t = IO_SOUND;
        else if (a >= 16'hDE00)
            t = IO_EXT;
        else if (a >= 16'hDD00)
            t = IO_CIA2;
        else if (a >= 16'hDC00)
            t = IO_CIA1;
        else
            t = IO_VIDEO;
        return t;
    endfunction

endpackage

FILE: rtl/core/banked_memory_map_decoder.sv
// Banked memory map decoder: RAM, three ROM images and the processor port.
// Depends on bmmd_pkg and banked_memory_map_decoder_macros.svh.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  in      | to block  | in_valid / in_ready | req_type, address, write_data
//  out     | from block| out_valid/out_ready | read_data, io_target
//
// One transaction per cycle sustained while out_ready stays high; a request
// passes the read stage and then the output register before out_valid rises.
// The registered read port of the RAM and ROM arrays sets this.
// Reset clears the pipeline valids and loads the port registers (direction
// 0x2F, output 0x37); memory contents are undefined until written.
// A stalled result holds the output register; the read stage holds behind it
// and in_ready drops only while both stages are full and out_ready is low.
`include "banked_memory_map_decoder_macros.svh"

module banked_memory_map_decoder (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  bmmd_pkg::req_t   req_type,
    input  bmmd_pkg::addr_t  address,
    input  bmmd_pkg::byte_t  write_data,
    output logic             out_valid,
    input  logic             out_ready,
    output bmmd_pkg::byte_t  read_data,
    output bmmd_pkg::io_t    io_target
);
    import bmmd_pkg::*;

    // Storage
    byte_t ram_mem  [RAM_DEPTH];
    byte_t kern_mem [KERN_DEPTH];
    byte_t bas_mem  [BAS_DEPTH];
    byte_t chr_mem  [CHR_DEPTH];

    byte_t ram_q_reg;
    byte_t kern_q_reg;
    byte_t bas_q_reg;
    byte_t chr_q_reg;

    // Processor port registers
    byte_t dir_reg;
    byte_t pout_reg;

    // Read stage (memory access in flight)
    logic  s1_valid_reg;
    src_t  s1_src_reg;
    byte_t s1_imm_reg;
    io_t   s1_tgt_reg;

    // Output stage
    logic  out_valid_reg;
    byte_t read_data_reg;
    io_t   io_target_reg;

    logic  in_fire;
    logic  s1_move;
    port_t pv;
    logic  hiram;
    logic  loram;
    logic  charen;
    logic  d_win;
    logic  io_vis;
    logic  is_read;
    logic  is_write;
    logic  ram_we;
    logic  ram_re;
    logic  kern_re;
    logic  bas_re;
    logic  chr_re;
    src_t  src_next;
    byte_t imm_next;
    io_t   tgt_next;
    byte_t mem_data;

    // Handshake: the read stage drains whenever the output register is free
    assign s1_move   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || s1_move;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign io_target = io_target_reg;

    // Banking decode from the current port value
    assign pv       = port_value(dir_reg, pout_reg);
    assign hiram    = pv[BIT_HIRAM];
    assign loram    = pv[BIT_LORAM];
    assign charen   = pv[BIT_CHAREN];
    assign d_win    = in_d_window(address);
    assign io_vis   = d_win && (hiram || loram) && charen;
    assign is_read  = (req_type == REQ_READ);
    assign is_write = (req_type == REQ_WRITE);

    always_comb
    begin
        src_next = SRC_IMM;
        imm_next = '0;
        tgt_next = IO_NONE;
        if (is_read)
        begin
            if (address == ADDR_DIR)
                imm_next = dir_reg;
            else if (address == ADDR_PORT)
                imm_next = {2'b00, pv};
            else if (address >= 16'hE000 && hiram)
                src_next = SRC_KERNAL;
            else if (d_win && (hiram || loram))
            begin
                if (charen)
                begin
                    imm_next = IO_FILL;
                    tgt_next = io_select(address);
                end
                else
                    src_next = SRC_CHAR;
            end
            else if (address inside {[16'hA000:16'hBFFF]} && hiram && loram)
                src_next = SRC_BASIC;
            else
                src_next = SRC_RAM;
        end
        else if (is_write && io_vis)
            tgt_next = io_select(address);
    end

    // Writes under a visible I/O window do not reach RAM
    assign ram_we  = in_fire && is_write && !io_vis;
    assign ram_re  = in_fire && is_read && (src_next == SRC_RAM);
    assign kern_re = in_fire && is_read && (src_next == SRC_KERNAL);
    assign bas_re  = in_fire && is_read && (src_next == SRC_BASIC);
    assign chr_re  = in_fire && is_read && (src_next == SRC_CHAR);

    always_ff @(posedge clk)
    begin
        if (ram_we)
            ram_mem[address] <= write_data;
        else if (ram_re)
            ram_q_reg <= ram_mem[address];
    end

    // ROM images: loads wrap the offset to the image size
    always_ff @(posedge clk)
    begin
        if (in_fire && req_type == REQ_LD_KERN)
            kern_mem[address[KERN_AW-1:0]] <= write_data;
        else if (kern_re)
            kern_q_reg <= kern_mem[address[KERN_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && req_type == REQ_LD_BASIC)
            bas_mem[address[BAS_AW-1:0]] <= write_data;
        else if (bas_re)
            bas_q_reg <= bas_mem[address[BAS_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && req_type == REQ_LD_CHAR)
            chr_mem[address[CHR_AW-1:0]] <= write_data;
        else if (chr_re)
            chr_q_reg <= chr_mem[address[CHR_AW-1:0]];
    end

    // Port registers; the same write also lands in RAM
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg  <= DIR_RESET;
            pout_reg <= OUT_RESET;
        end
        else if (in_fire && is_write)
        begin
            if (address == ADDR_DIR)
                dir_reg <= write_data;
            else if (address == ADDR_PORT)
                pout_reg <= write_data;
        end
    end

    // Read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_src_reg <= src_next;
            s1_imm_reg <= imm_next;
            s1_tgt_reg <= tgt_next;
        end
    end

    always_comb
    begin
        case (s1_src_reg)
            SRC_RAM:    mem_data = ram_q_reg;
            SRC_KERNAL: mem_data = kern_q_reg;
            SRC_BASIC:  mem_data = bas_q_reg;
            SRC_CHAR:   mem_data = chr_q_reg;
            default:    mem_data = s1_imm_reg;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_valid_reg && s1_move)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_move)
        begin
            read_data_reg <= mem_data;
            io_target_reg <= s1_tgt_reg;
        end
    end

    `BMMD_ASSERT_NEXT(a_s1_hold, s1_valid_reg && out_valid_reg && !out_ready, s1_valid_reg, "read stage lost while output stalled")
    `BMMD_ASSERT_NEXT(a_s1_drain, s1_valid_reg && s1_move, out_valid_reg, "read stage drained without a result")
    `BMMD_ASSERT(a_io_no_ram, !(ram_we && io_vis), "RAM written under visible I/O window")
    `BMMD_ASSERT(a_io_data, !(out_valid_reg && io_target_reg != IO_NONE) || read_data_reg == IO_FILL || read_data_reg == 8'h00, "device select with unexpected read data")

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for banked_memory_map_decoder: directed and random bus traffic.
// Depends on bmmd_pkg and the RTL of banked_memory_map_decoder. Reads no files.
`timescale 1ns / 1ps

module tb_top;
    import bmmd_pkg::*;

    // Request codes the block must ignore (outside the defined operations)
    localparam req_t REQ_RSVD_FIRST = 3'd5;
    localparam req_t REQ_RSVD_LAST  = 3'd7;

    // Map windows
    localparam addr_t WIN_BASIC     = 16'hA000;
    localparam addr_t WIN_BASIC_END = 16'hC000;
    localparam addr_t WIN_IO        = 16'hD000;
    localparam addr_t WIN_KERNAL    = 16'hE000;

    // Device ranges inside the I/O window
    localparam addr_t SND_LO  = 16'hD400;
    localparam addr_t SND_END = 16'hD800;
    localparam addr_t CIA1_LO = 16'hDC00;
    localparam addr_t CIA2_LO = 16'hDD00;
    localparam addr_t EXT_LO  = 16'hDE00;

    localparam int RANDOM_ITEMS = 500;
    localparam int DRAIN_CYCLES = 10;

    // Where a read is answered from, given the address and the port setting
    typedef enum {FROM_DIR, FROM_PORT, FROM_KERNAL, FROM_IO, FROM_CHAR, FROM_BASIC, FROM_RAM}
        read_src_t;

    typedef struct packed {
        byte_t read_data;
        io_t   io_target;
    } bus_reply_t;

    // One row of the directed script. When has_fixed is set the reply is typed in
    // here; otherwise it comes from the shadow memory map.
    typedef struct {
        req_t  req;
        addr_t addr;
        byte_t data;
        bit    has_fixed;
        byte_t rd;
        io_t   io;
    } script_row_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    req_t    req_type = REQ_READ;
    addr_t   address = '0;
    byte_t   write_data = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    byte_t   read_data;
    io_t     io_target;

    // Shadow copy of the memory map. The *_known flags keep the stimulus away
    // from bytes that were never written, which the block leaves undefined.
    byte_t   ram_img    [0:RAM_DEPTH-1];
    bit      ram_known  [0:RAM_DEPTH-1];
    byte_t   kern_img   [0:KERN_DEPTH-1];
    bit      kern_known [0:KERN_DEPTH-1];
    byte_t   basic_img  [0:BAS_DEPTH-1];
    bit      basic_known[0:BAS_DEPTH-1];
    byte_t   char_img   [0:CHR_DEPTH-1];
    bit      char_known [0:CHR_DEPTH-1];
    byte_t   port_dir_q = DIR_RESET;
    byte_t   port_out_q = OUT_RESET;

    // Bus addresses through which something written can be read back
    addr_t   known_addrs[$];

    // Replies still owed by the block, oldest first
    bus_reply_t replies_due[$];
    bus_reply_t want;

    int      n_sent = 0;
    int      n_checked = 0;
    int      n_fail = 0;
    int      n_io = 0;
    bit [7:0] banks_seen = '0;   // port bank settings (CHAREN/HIRAM/LORAM) seen on reads

    int      burst_left = 0;
    int      stall_left = 0;
    int      rx_tick = 0;

    script_row_t script [25] = '{
        // Port registers straight out of reset
        '{REQ_READ,       16'h0000, 8'h00, 1'b1, 8'h2F, IO_NONE},
        '{REQ_READ,       16'h0001, 8'h00, 1'b1, 8'h37, IO_NONE},
        // Every device select, I/O visible by default
        '{REQ_READ,       16'hD000, 8'h00, 1'b1, 8'hFF, IO_VIDEO},
        '{REQ_READ,       16'hD400, 8'h00, 1'b1, 8'hFF, IO_SOUND},
        '{REQ_READ,       16'hD800, 8'h00, 1'b1, 8'hFF, IO_VIDEO},
        '{REQ_READ,       16'hDC00, 8'h00, 1'b1, 8'hFF, IO_CIA1},
        '{REQ_READ,       16'hDD00, 8'h00, 1'b1, 8'hFF, IO_CIA2},
        '{REQ_READ,       16'hDE00, 8'h00, 1'b1, 8'hFF, IO_EXT},
        // I/O write skips RAM and still reports the device
        '{REQ_WRITE,      16'hDFFF, 8'hAA, 1'b1, 8'h00, IO_EXT},
        // ROM loads, including offsets that wrap
        '{REQ_LD_KERN,    16'h0000, 8'h00, 1'b1, 8'h00, IO_NONE},
        '{REQ_LD_KERN,    16'hFFFF, 8'hFF, 1'b1, 8'h00, IO_NONE},
        '{REQ_READ,       16'hE000, 8'h00, 1'b0, 8'h00, IO_NONE},
        '{REQ_READ,       16'hFFFF, 8'h00, 1'b0, 8'h00, IO_NONE},
        '{REQ_LD_BASIC,   16'h2000, 8'h56, 1'b1, 8'h00, IO_NONE},
        '{REQ_READ,       16'hA000, 8'h00, 1'b0, 8'h00, IO_NONE},
        '{REQ_LD_CHAR,    16'hF123, 8'h78, 1'b1, 8'h00, IO_NONE},
        // Write under the visible kernal lands in RAM
        '{REQ_WRITE,      16'hE005, 8'h9C, 1'b1, 8'h00, IO_NONE},
        // Reserved request codes do nothing
        '{REQ_RSVD_FIRST, 16'hFFFF, 8'hFF, 1'b1, 8'h00, IO_NONE},
        '{REQ_RSVD_LAST,  16'h0000, 8'h55, 1'b1, 8'h00, IO_NONE},
        // CHAREN low: the D window shows the character ROM
        '{REQ_WRITE,      16'h0001, 8'h33, 1'b1, 8'h00, IO_NONE},
        '{REQ_READ,       16'hD123, 8'h00, 1'b0, 8'h00, IO_NONE},
        // All outputs driven, all bank bits low: everything is RAM
        '{REQ_WRITE,      16'h0000, 8'hFF, 1'b1, 8'h00, IO_NONE},
        '{REQ_WRITE,      16'h0001, 8'h30, 1'b1, 8'h00, IO_NONE},
        '{REQ_READ,       16'hE005, 8'h00, 1'b0, 8'h00, IO_NONE},
        '{REQ_READ,       16'h0001, 8'h00, 1'b1, 8'h30, IO_NONE}
    };

    banked_memory_map_decoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .address   (address),
        .write_data(write_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_data (read_data),
        .io_target (io_target)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow memory map
    // ------------------------------------------------------------------

    // Effective processor port: undriven pins float high
    function automatic port_t eff_port();
        byte_t v;
        v = port_out_q | ~port_dir_q;
        return v[5:0];
    endfunction

    function automatic io_t device_for(input addr_t a);
        if (a >= SND_LO && a < SND_END)
            return IO_SOUND;
        if (a >= EXT_LO)
            return IO_EXT;
        if (a >= CIA2_LO)
            return IO_CIA2;
        if (a >= CIA1_LO)
            return IO_CIA1;
        return IO_VIDEO;
    endfunction

    // Priority follows the map: port regs, kernal, D window, basic, RAM
    function automatic read_src_t read_source(input addr_t a, input port_t pv);
        if (a == ADDR_DIR)
            return FROM_DIR;
        if (a == ADDR_PORT)
            return FROM_PORT;
        if (a >= WIN_KERNAL && pv[BIT_HIRAM])
            return FROM_KERNAL;
        if (a >= WIN_IO && a < WIN_KERNAL && (pv[BIT_HIRAM] || pv[BIT_LORAM]))
            return pv[BIT_CHAREN] ? FROM_IO : FROM_CHAR;
        if (a >= WIN_BASIC && a < WIN_BASIC_END && pv[BIT_HIRAM] && pv[BIT_LORAM])
            return FROM_BASIC;
        return FROM_RAM;
    endfunction

    function automatic bit byte_is_known(input addr_t a);
        case (read_source(a, eff_port()))
            FROM_KERNAL: return kern_known[a[12:0]];
            FROM_CHAR:   return char_known[a[11:0]];
            FROM_BASIC:  return basic_known[a[12:0]];
            FROM_RAM:    return ram_known[a];
            default:     return 1'b1;
        endcase
    endfunction

    // Applies one bus transaction to the shadow map and returns the reply it owes
    function automatic void apply_access(input req_t r, input addr_t a, input byte_t d,
                                         output byte_t rd, output io_t io);
        port_t pv;
        pv = eff_port();
        rd = '0;
        io = IO_NONE;
        case (r)
            REQ_READ:
            begin
                case (read_source(a, pv))
                    FROM_DIR:    rd = port_dir_q;
                    FROM_PORT:   rd = {2'b00, pv};
                    FROM_KERNAL: rd = kern_img[a[12:0]];
                    FROM_CHAR:   rd = char_img[a[11:0]];
                    FROM_BASIC:  rd = basic_img[a[12:0]];
                    FROM_IO:
                    begin
                        rd = IO_FILL;
                        io = device_for(a);
                    end
                    default:     rd = ram_img[a];
                endcase
            end
            REQ_WRITE:
            begin
                if (a == ADDR_DIR)
                    port_dir_q = d;
                else if (a == ADDR_PORT)
                    port_out_q = d;
                // Decode uses the port setting from before this write
                if (read_source(a, pv) == FROM_IO)
                    io = device_for(a);
                else
                begin
                    ram_img[a] = d;
                    ram_known[a] = 1'b1;
                    known_addrs.push_back(a);
                end
            end
            REQ_LD_KERN:
            begin
                kern_img[a[12:0]] = d;
                kern_known[a[12:0]] = 1'b1;
                known_addrs.push_back(WIN_KERNAL + addr_t'(a[12:0]));
            end
            REQ_LD_BASIC:
            begin
                basic_img[a[12:0]] = d;
                basic_known[a[12:0]] = 1'b1;
                known_addrs.push_back(WIN_BASIC + addr_t'(a[12:0]));
            end
            REQ_LD_CHAR:
            begin
                char_img[a[11:0]] = d;
                char_known[a[11:0]] = 1'b1;
                known_addrs.push_back(WIN_IO + addr_t'(a[11:0]));
            end
            default:
            begin
                // reserved codes leave everything alone
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------

    // Read address whose answer is defined under the current port setting.
    // Mostly addresses written earlier, some I/O window, a few port regs.
    function automatic addr_t pick_read_addr();
        int    t;
        int    kind;
        addr_t a;
        for (t = 0; t < 8; t++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7 && known_addrs.size() != 0)
                a = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
            else if (kind < 9)
                a = WIN_IO + addr_t'($urandom_range(0, 12'hFFF));
            else
                a = $urandom_range(0, 1) ? ADDR_PORT : ADDR_DIR;
            if (byte_is_known(a))
                return a;
        end
        return ADDR_PORT;
    endfunction

    // Writes lean toward the banked windows so later reads hit them
    function automatic addr_t pick_write_addr();
        case ($urandom_range(0, 4))
            0:       return WIN_IO + addr_t'($urandom_range(0, 12'hFFF));
            1:       return WIN_KERNAL + addr_t'($urandom_range(0, 13'h1FFF));
            2:       return WIN_BASIC + addr_t'($urandom_range(0, 13'h1FFF));
            3:       return addr_t'($urandom_range(0, 8'hFF));
            default: return addr_t'($urandom);
        endcase
    endfunction

    task automatic pick_random(output req_t r, output addr_t a, output byte_t d);
        int sel;
        sel = $urandom_range(0, 99);
        d = byte_t'($urandom);
        if (sel < 38)
        begin
            r = REQ_READ;
            a = pick_read_addr();
        end
        else if (sel < 66)
        begin
            r = REQ_WRITE;
            a = pick_write_addr();
        end
        else if (sel < 74)
        begin
            // port reprogramming: walks the bank settings
            r = REQ_WRITE;
            a = $urandom_range(0, 1) ? ADDR_PORT : ADDR_DIR;
        end
        else if (sel < 94)
        begin
            // full 16-bit offset exercises the wrap
            r = req_t'($urandom_range(REQ_LD_KERN, REQ_LD_CHAR));
            a = addr_t'($urandom);
        end
        else
        begin
            r = req_t'($urandom_range(REQ_RSVD_FIRST, REQ_RSVD_LAST));
            a = addr_t'($urandom);
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of back-to-back transactions separated by random gaps.
    // Payload changes at the falling edge; acceptance is seen at the rising
    // edge, where the shadow map is updated and the reply queued.
    // ------------------------------------------------------------------
    task automatic send_access(input req_t r, input addr_t a, input byte_t d,
                               input bit has_fixed, input byte_t fixed_rd,
                               input io_t fixed_io);
        int         gap;
        byte_t      prd;
        io_t        pio;
        bus_reply_t due;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        req_type   <= r;
        address    <= a;
        write_data <= d;
        burst_left--;
        do
            @(posedge clk);
        while (!in_ready);

        if (r == REQ_READ)
            banks_seen[3'(eff_port())] = 1'b1;
        apply_access(r, a, d, prd, pio);
        due.read_data = has_fixed ? fixed_rd : prd;
        due.io_target = has_fixed ? fixed_io : pio;
        if (due.io_target != IO_NONE)
            n_io++;
        replies_due.push_back(due);
        n_sent++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall intensity cycles through calm, light and heavy stretches
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rx_tick++;
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                // level 0 never stalls, 1 stalls briefly, 2 stalls often and long
                if ($urandom_range(0, 5) < 2 * ((rx_tick / 48) % 3))
                    stall_left = $urandom_range(1, 4 * ((rx_tick / 48) % 3));
            end
        end
    end

    // ------------------------------------------------------------------
    // Reply checker: every accepted reply against the oldest one owed
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (replies_due.size() == 0)
            begin
                $error("reply %0d arrived with no transaction pending", n_checked);
                n_fail++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (read_data !== want.read_data)
                begin
                    $error("reply %0d read_data: expected %02h, actual %02h",
                           n_checked, want.read_data, read_data);
                    n_fail++;
                end
                if (io_target !== want.io_target)
                begin
                    $error("reply %0d io_target: expected %0d, actual %0d",
                           n_checked, want.io_target, io_target);
                    n_fail++;
                end
            end
            n_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int    i;
        req_t  r;
        addr_t a;
        byte_t d;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < $size(script); i++)
            send_access(script[i].req, script[i].addr, script[i].data,
                        script[i].has_fixed, script[i].rd, script[i].io);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick_random(r, a, d);
            send_access(r, a, d, 1'b0, '0, IO_NONE);
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // Drain, then give stray replies a chance to show up
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d bus transactions (%0d device selects), %0d replies checked.",
                 n_sent, n_io, n_checked);
        $display("Bank settings read under (bit per CHAREN/HIRAM/LORAM value): %b", banks_seen);
        if (n_fail == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Watchdog: roughly ten times the slowest legal run
    initial
    begin
        #400_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/bmmd_pkg.sv
rtl/core/banked_memory_map_decoder.sv
tb/tb_top.sv
